// ----- sv/lemp_pkg.sv -----
// shared constants, widths and the queue entry type of the edge pooling core
`default_nettype none

package lemp_pkg;

  // image geometry and pooling
  localparam int IMG_WIDTH  = 64;
  localparam int IMG_HEIGHT = 40;
  localparam int POOL_SIZE  = 4;
  localparam int CHANNELS   = 3;

  localparam int BLOCKS_X = IMG_WIDTH / POOL_SIZE;
  localparam int BLOCKS_Y = IMG_HEIGHT / POOL_SIZE;

  // sample and pixel widths
  localparam int CHAN_W = 8;
  localparam int NIB_W  = 4;
  localparam int NUM_CH = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int PIX_W  = NIB_W * NUM_CH;

  // threshold register
  localparam int              THR_W     = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd30;

  // result coordinate width
  localparam int BLK_W = 4;

  // position counters
  localparam int COL_W  = $clog2(IMG_WIDTH);
  localparam int ROW_W  = $clog2(IMG_HEIGHT);
  localparam int CPH_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CBLK_W = $clog2(BLOCKS_X + 1);
  localparam int RBLK_W = $clog2(BLOCKS_Y + 1);
  localparam int BX_W   = (BLOCKS_X > 1) ? $clog2(BLOCKS_X) : 1;
  localparam int BY_W   = (BLOCKS_Y > 1) ? $clog2(BLOCKS_Y) : 1;

  // laplacian arithmetic
  localparam int MAX_LAP = 4 * ((1 << NIB_W) - 1);
  localparam int LAP_W   = 8;
  localparam int SUM_W   = $clog2(MAX_LAP * NUM_CH + 1);
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // one classified pixel
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic             fstart;
    logic             eval;
    logic             emit;
    logic             wrap;
    logic             last;
    logic [BX_W-1:0]  bx;
    logic [BY_W-1:0]  by;
  } lemp_item_t;

endpackage

`default_nettype wire

// ----- sv/lemp_pix_if.sv -----
// pixel channel: valid/ready with three colour samples and a frame marker
`default_nettype none

interface lemp_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_start;
  logic [lemp_pkg::CHAN_W-1:0] chan_a;
  logic [lemp_pkg::CHAN_W-1:0] chan_b;
  logic [lemp_pkg::CHAN_W-1:0] chan_c;

  modport source (output valid, frame_start, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, frame_start, chan_a, chan_b, chan_c, output ready);
endinterface

`default_nettype wire

// ----- sv/lemp_blk_if.sv -----
// block result channel: valid/ready with block coordinates, edge flag and last-block marker
`default_nettype none

interface lemp_blk_if;
  logic                       valid;
  logic                       ready;
  logic [lemp_pkg::BLK_W-1:0] block_col;
  logic [lemp_pkg::BLK_W-1:0] block_row;
  logic                       edge_found;
  logic                       frame_last;

  modport source (output valid, block_col, block_row, edge_found, frame_last,
                  input ready);
  modport sink   (input valid, block_col, block_row, edge_found, frame_last,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/lemp_front.sv -----
// front end: pixel position tracking and per-pixel classification
`default_nettype none

module lemp_front (
  input  wire                  clk,
  input  wire                  rst,
  lemp_pix_if.sink             pixels,
  input  wire                  full,
  output logic                 push,
  output lemp_pkg::lemp_item_t push_item
);

  logic [lemp_pkg::COL_W-1:0]  col,  col_e,  col_next;
  logic [lemp_pkg::ROW_W-1:0]  row,  row_e,  row_next;
  logic [lemp_pkg::CPH_W-1:0]  cph,  cph_e,  cph_next;
  logic [lemp_pkg::CBLK_W-1:0] cblk, cblk_e, cblk_next;
  logic [lemp_pkg::CPH_W-1:0]  rph,  rph_e,  rph_next;
  logic [lemp_pkg::RBLK_W-1:0] rblk, rblk_e, rblk_next;
  // phase and block index of the centre row (one above the incoming row)
  logic [lemp_pkg::CPH_W-1:0]  yph,  yph_e,  yph_next;
  logic [lemp_pkg::RBLK_W-1:0] yblk, yblk_e, yblk_next;

  logic col_end, row_end, cph_end, rph_end, in_blocks;
  logic [3*lemp_pkg::NIB_W-1:0] pix_all;

  assign pixels.ready = !full;
  assign push         = pixels.valid && !full;

  always_comb begin
    if (pixels.frame_start) begin
      col_e  = '0;
      row_e  = '0;
      cph_e  = '0;
      cblk_e = '0;
      rph_e  = '0;
      rblk_e = '0;
      yph_e  = '0;
      yblk_e = '0;
    end else begin
      col_e  = col;
      row_e  = row;
      cph_e  = cph;
      cblk_e = cblk;
      rph_e  = rph;
      rblk_e = rblk;
      yph_e  = yph;
      yblk_e = yblk;
    end
  end

  assign col_end = (col_e == lemp_pkg::COL_W'(lemp_pkg::IMG_WIDTH - 1));
  assign row_end = (row_e == lemp_pkg::ROW_W'(lemp_pkg::IMG_HEIGHT - 1));
  assign cph_end = (cph_e == lemp_pkg::CPH_W'(lemp_pkg::POOL_SIZE - 1));
  assign rph_end = (rph_e == lemp_pkg::CPH_W'(lemp_pkg::POOL_SIZE - 1));

  assign in_blocks = (cblk_e < lemp_pkg::CBLK_W'(lemp_pkg::BLOCKS_X)) &&
                     (yblk_e < lemp_pkg::RBLK_W'(lemp_pkg::BLOCKS_Y));

  assign pix_all = {pixels.chan_c[lemp_pkg::CHAN_W-1 -: lemp_pkg::NIB_W],
                    pixels.chan_b[lemp_pkg::CHAN_W-1 -: lemp_pkg::NIB_W],
                    pixels.chan_a[lemp_pkg::CHAN_W-1 -: lemp_pkg::NIB_W]};

  always_comb begin
    push_item.pix    = lemp_pkg::PIX_W'(pix_all);
    push_item.col    = col_e;
    push_item.fstart = pixels.frame_start;
    push_item.eval   = (row_e >= lemp_pkg::ROW_W'(2)) && (col_e != '0) && !col_end &&
                       in_blocks;
    push_item.emit   = (row_e != '0) && cph_end && in_blocks &&
                       ((yph_e == lemp_pkg::CPH_W'(lemp_pkg::POOL_SIZE - 1)) || row_end);
    push_item.wrap   = col_end && row_end;
    push_item.last   = (cblk_e == lemp_pkg::CBLK_W'(lemp_pkg::BLOCKS_X - 1)) &&
                       (yblk_e == lemp_pkg::RBLK_W'(lemp_pkg::BLOCKS_Y - 1));
    push_item.bx     = lemp_pkg::BX_W'(cblk_e);
    push_item.by     = lemp_pkg::BY_W'(yblk_e);
  end

  always_comb begin
    col_next  = col_e + lemp_pkg::COL_W'(1);
    cph_next  = cph_end ? '0 : cph_e + lemp_pkg::CPH_W'(1);
    cblk_next = cph_end ? cblk_e + lemp_pkg::CBLK_W'(1) : cblk_e;
    row_next  = row_e;
    rph_next  = rph_e;
    rblk_next = rblk_e;
    yph_next  = yph_e;
    yblk_next = yblk_e;
    if (col_end) begin
      col_next  = '0;
      cph_next  = '0;
      cblk_next = '0;
      if (row_end) begin
        row_next  = '0;
        rph_next  = '0;
        rblk_next = '0;
        yph_next  = '0;
        yblk_next = '0;
      end else begin
        row_next  = row_e + lemp_pkg::ROW_W'(1);
        rph_next  = rph_end ? '0 : rph_e + lemp_pkg::CPH_W'(1);
        rblk_next = rph_end ? rblk_e + lemp_pkg::RBLK_W'(1) : rblk_e;
        yph_next  = rph_e;
        yblk_next = rblk_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      cph  <= '0;
      cblk <= '0;
      rph  <= '0;
      rblk <= '0;
      yph  <= '0;
      yblk <= '0;
    end else if (push) begin
      col  <= col_next;
      row  <= row_next;
      cph  <= cph_next;
      cblk <= cblk_next;
      rph  <= rph_next;
      rblk <= rblk_next;
      yph  <= yph_next;
      yblk <= yblk_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lemp_fifo.sv -----
// short queue of classified pixels between front and back
`default_nettype none

module lemp_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  lemp_pkg::lemp_item_t push_item,
  output logic                 full,
  input  wire                  pop,
  output logic                 head_valid,
  output lemp_pkg::lemp_item_t head_item
);

  lemp_pkg::lemp_item_t entries [lemp_pkg::FIFO_DEPTH];

  logic [lemp_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [lemp_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [lemp_pkg::FIFO_PTR_W:0]   count;

  assign full       = (count == (lemp_pkg::FIFO_PTR_W + 1)'(lemp_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lemp_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lemp_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (lemp_pkg::FIFO_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (lemp_pkg::FIFO_PTR_W + 1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (lemp_pkg::FIFO_PTR_W + 1)'(lemp_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ----- sv/lemp_back.sv -----
// back end: line store, laplacian sum, threshold, block pooling and result register
`default_nettype none

module lemp_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire [lemp_pkg::THR_W-1:0] thr,
  input  wire                       head_valid,
  input  lemp_pkg::lemp_item_t      head_item,
  output logic                      pop,
  lemp_blk_if.source                blocks
);

  localparam int ENT_W = 2 * lemp_pkg::PIX_W;

  // each entry holds {row above, two rows above} for one column
  logic [ENT_W-1:0]          line_mem [lemp_pkg::IMG_WIDTH];
  logic [ENT_W-1:0]          mem_rd_c;
  logic [lemp_pkg::PIX_W-1:0] mem_rd_r;

  logic [lemp_pkg::COL_W-1:0] raddr_c;
  logic [lemp_pkg::COL_W-1:0] raddr_r;

  logic adv;

  // read stage
  logic                       s1_valid;
  lemp_pkg::lemp_item_t       s1;
  logic                       fwd_c_hit;
  logic                       fwd_r_hit;
  logic [lemp_pkg::PIX_W-1:0] fwd_pix;
  logic [lemp_pkg::PIX_W-1:0] fwd_above;
  logic [lemp_pkg::PIX_W-1:0] left_q;
  logic [lemp_pkg::PIX_W-1:0] centre;
  logic [lemp_pkg::PIX_W-1:0] up;
  logic [lemp_pkg::PIX_W-1:0] right;
  logic [lemp_pkg::SUM_W-1:0] sum;

  // pool stage
  logic                       s2_valid;
  lemp_pkg::lemp_item_t       s2;
  logic [lemp_pkg::SUM_W-1:0] s2_sum;
  logic [lemp_pkg::BLOCKS_X-1:0] acc;
  logic [lemp_pkg::BLOCKS_X-1:0] acc_base;
  logic [lemp_pkg::BLOCKS_X-1:0] acc_next;
  logic                          hit;
  logic                          blk_bit;

  assign adv = !blocks.valid || blocks.ready;
  assign pop = adv && head_valid;

  assign raddr_c = head_item.col;
  assign raddr_r = (head_item.col == lemp_pkg::COL_W'(lemp_pkg::IMG_WIDTH - 1)) ?
                   '0 : head_item.col + lemp_pkg::COL_W'(1);

  assign centre = fwd_c_hit ? fwd_pix   : mem_rd_c[ENT_W-1:lemp_pkg::PIX_W];
  assign up     = fwd_c_hit ? fwd_above : mem_rd_c[lemp_pkg::PIX_W-1:0];
  assign right  = fwd_r_hit ? fwd_pix   : mem_rd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_valid) begin
        line_mem[s1.col] <= {s1.pix, centre};
      end
      mem_rd_c <= line_mem[raddr_c];
      mem_rd_r <= line_mem[raddr_r][ENT_W-1:lemp_pkg::PIX_W];
    end
  end

  always_comb begin
    logic [lemp_pkg::LAP_W-1:0] v;
    logic [lemp_pkg::LAP_W-1:0] mag;
    sum = '0;
    for (int ch = 0; ch < lemp_pkg::NUM_CH; ch++) begin
      v = lemp_pkg::LAP_W'({centre[ch*lemp_pkg::NIB_W +: lemp_pkg::NIB_W], 2'b00})
        - lemp_pkg::LAP_W'(left_q[ch*lemp_pkg::NIB_W +: lemp_pkg::NIB_W])
        - lemp_pkg::LAP_W'(right[ch*lemp_pkg::NIB_W +: lemp_pkg::NIB_W])
        - lemp_pkg::LAP_W'(up[ch*lemp_pkg::NIB_W +: lemp_pkg::NIB_W])
        - lemp_pkg::LAP_W'(s1.pix[ch*lemp_pkg::NIB_W +: lemp_pkg::NIB_W]);
      mag = v[lemp_pkg::LAP_W-1] ? (~v + lemp_pkg::LAP_W'(1)) : v;
      sum = sum + lemp_pkg::SUM_W'(mag);
    end
  end

  always_comb begin
    acc_base = s2.fstart ? '0 : acc;
    hit      = s2.eval &&
               (lemp_pkg::CMP_W'(s2_sum) > lemp_pkg::CMP_W'(thr));
    blk_bit  = acc_base[s2.bx] || hit;
    acc_next = acc_base;
    if (hit) begin
      acc_next[s2.bx] = 1'b1;
    end
    if (s2.emit) begin
      acc_next[s2.bx] = 1'b0;
    end
    if (s2.wrap) begin
      acc_next = '0;
    end
  end

  // payload of the pipeline stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1        <= head_item;
      fwd_c_hit <= s1_valid && (s1.col == raddr_c);
      fwd_r_hit <= s1_valid && (s1.col == raddr_r);
      fwd_pix   <= s1.pix;
      fwd_above <= centre;
      s2        <= s1;
      s2_sum    <= sum;
    end
  end

  // control and pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      left_q   <= '0;
      acc      <= '0;
    end else if (adv) begin
      s1_valid <= head_valid;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        left_q <= centre;
      end
      if (s2_valid) begin
        acc <= acc_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks.valid <= 1'b0;
    end else if (adv) begin
      blocks.valid      <= s2_valid && s2.emit;
      blocks.block_col  <= lemp_pkg::BLK_W'(s2.bx);
      blocks.block_row  <= lemp_pkg::BLK_W'(s2.by);
      blocks.edge_found <= blk_bit;
      blocks.frame_last <= s2.last;
    end
  end

  a_last_coords: assert property (@(posedge clk) disable iff (rst)
    blocks.valid && blocks.frame_last |->
      blocks.block_col == lemp_pkg::BLK_W'(lemp_pkg::BLOCKS_X - 1) &&
      blocks.block_row == lemp_pkg::BLK_W'(lemp_pkg::BLOCKS_Y - 1))
    else $error("frame_last on a block other than the bottom right");

  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    adv && s2_valid && s2.wrap |=> acc == '0)
    else $error("pool bits not cleared at frame end");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_valid) && $stable(s2_valid) && $stable(acc))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// ----- sv/laplacian_edge_max_pool_core.sv -----
// top level of the laplacian edge detector with 4x4 or-pooled block output
// result path: queue entry, read stage, pool stage, then the registered block result
// throughput: one pixel per cycle while the queue is not full, set by the single line-store write per pixel
// a 4-entry queue decouples the pixel side from the result side
// reset (rst, synchronous): position counters, queue, pipeline valids and pool bits clear,
// threshold returns to 30; the line store is not cleared and holds no valid state
`default_nettype none

module laplacian_edge_max_pool_core (
  input  wire                       clk,
  input  wire                       rst,
  lemp_pix_if.sink                  pixels,
  lemp_blk_if.source                blocks,
  input  wire                       cfg_wr_en,
  input  wire [lemp_pkg::THR_W-1:0] cfg_wr_data
);

  // edge threshold register; the user must write it only while the core is idle, the block does not enforce this
  logic [lemp_pkg::THR_W-1:0] edge_threshold;

  // front to queue
  logic                 push;
  logic                 full;
  lemp_pkg::lemp_item_t push_item;

  // queue to back
  logic                 pop;
  logic                 head_valid;
  lemp_pkg::lemp_item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= lemp_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      edge_threshold <= cfg_wr_data;
    end
  end

  // front: tracks raster position and tags each pixel with what the back
  // must do (evaluate, emit a block, clear the pool bits)
  lemp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // short queue so the pixel side keeps flowing while a result waits
  lemp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: line store read, laplacian, threshold, pooling, result register
  lemp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .thr        (edge_threshold),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .blocks     (blocks)
  );

endmodule

`default_nettype wire
